[src/rgcw_pkg.sv]
package rgcw_pkg;

    // Field and datapath widths
    localparam int COORD_W  = 16;   // signed Q8.8 coordinate
    localparam int DIR_W    = 16;   // signed Q1.14 direction
    localparam int LEN_W    = 15;   // unsigned Q7.8 length / cell size
    localparam int FRAC_W   = 14;   // fraction bits of the direction
    localparam int DELTA_W  = 17;   // end minus start, signed
    localparam int CELL_W   = 5;    // column / row index
    localparam int STEP_W   = 7;    // signed index one step past the grid
    localparam int DIV_D_W  = 19;   // coordinate minus grid origin, signed
    localparam int QBITS    = 5;    // quotient bits produced by the divider
    localparam int BND_W    = 24;   // cell boundary, signed Q16.8
    localparam int MUL_A_W  = 25;
    localparam int MUL_B_W  = 18;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
    localparam int NUM_W    = MUL_P_W + 1;
    localparam int CNT_W    = 5;
    localparam int MAX_CELLS = 24;

    // Configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_X       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y       = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT = 8'd3;

    // Register reset values
    localparam logic signed [COORD_W-1:0] MIN_X_RST = -16'sd2048;
    localparam logic signed [COORD_W-1:0] MIN_Y_RST = -16'sd3584;
    localparam logic [LEN_W-1:0] CELL_W_RST = 15'd410;
    localparam logic [LEN_W-1:0] CELL_H_RST = 15'd495;

    typedef logic signed [MUL_A_W-1:0] mul_a_t;
    typedef logic signed [MUL_B_W-1:0] mul_b_t;
    typedef logic signed [MUL_P_W-1:0] mul_p_t;
    typedef logic signed [DIV_D_W-1:0] div_d_t;
    typedef logic [CELL_W-1:0]         cell_t;

endpackage

[src/ray_grid_cell_walk.sv]
// Ray grid cell walk.
// Input channel (s_*): one word per ray, origin (Q8.8), direction (Q1.14) and
// length (Q7.8). s_ready is high only while the block is idle; one ray is
// worked at a time.
// Output channel (m_*): one word per crossed cell, in walk order; m_last_cell
// marks the final cell of the ray. At most 24 words per ray.
// Config channel (cfg_*): always ready; index 0..3 writes min_x, min_y,
// cell_width, cell_height; other indexes are ignored. Write only while idle.
// Sequence: the end point on the shared multiplier, then the four cell lookups
// one after another on the divider, then for a diagonal walk the boundaries seeded;
// then per cell a single check-and-step state on a straight walk, or check, two
// multiplies and decide on a diagonal walk; a closing state pushes the last cell.
// The output register lets the next cell be computed while the current word
// waits; when the receiver stalls, the walk holds at its next push.
// Reset (aresetn, synchronous) returns to idle, drops m_valid and restores
// the config registers to their defaults.
module ray_grid_cell_walk #(
    parameter int GRID_COLUMNS = 10,
    parameter int GRID_ROWS    = 15
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // config write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rgcw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rgcw_pkg::COORD_W-1:0]      cfg_data,
    // ray input
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [rgcw_pkg::COORD_W-1:0] s_origin_x,
    input  logic signed [rgcw_pkg::COORD_W-1:0] s_origin_y,
    input  logic signed [rgcw_pkg::DIR_W-1:0]   s_dir_x,
    input  logic signed [rgcw_pkg::DIR_W-1:0]   s_dir_y,
    input  logic [rgcw_pkg::LEN_W-1:0]        s_ray_length,
    // cell output
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rgcw_pkg::CELL_W-1:0]       m_cell_col,
    output logic [rgcw_pkg::CELL_W-1:0]       m_cell_row,
    output logic                              m_last_cell
);

    localparam rgcw_pkg::cell_t COL_LAST = rgcw_pkg::CELL_W'(GRID_COLUMNS - 1);
    localparam rgcw_pkg::cell_t ROW_LAST = rgcw_pkg::CELL_W'(GRID_ROWS - 1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_EX   = 4'd1;   // x end point
    localparam logic [3:0] ST_EY   = 4'd2;   // y end point
    localparam logic [3:0] ST_DIVS = 4'd3;   // start a cell lookup
    localparam logic [3:0] ST_DIVW = 4'd4;   // wait for the lookup
    localparam logic [3:0] ST_BX   = 4'd5;   // seed column boundary
    localparam logic [3:0] ST_BY   = 4'd6;   // seed row boundary
    localparam logic [3:0] ST_CHK  = 4'd7;   // end test / straight step
    localparam logic [3:0] ST_M1   = 4'd8;   // (y0 - yd) * dx
    localparam logic [3:0] ST_M2   = 4'd9;   // + (xd - x0) * dy
    localparam logic [3:0] ST_DEC  = 4'd10;  // pick the next cell
    localparam logic [3:0] ST_FIN  = 4'd11;  // push the last cell

    localparam logic [1:0] LK_COL  = 2'd0;
    localparam logic [1:0] LK_ROW  = 2'd1;
    localparam logic [1:0] LK_ECOL = 2'd2;
    localparam logic [1:0] LK_EROW = 2'd3;

    localparam int CW = rgcw_pkg::COORD_W;
    localparam int DW = rgcw_pkg::DELTA_W;
    localparam int SW = rgcw_pkg::STEP_W;

    // config registers
    logic signed [CW-1:0]              min_x_reg, min_y_reg;
    logic [rgcw_pkg::LEN_W-1:0]        cw_reg, ch_reg;
    logic [rgcw_pkg::LEN_W-1:0]        cw_eff, ch_eff;

    // control
    logic [3:0]                        state_reg, state_next;
    logic [1:0]                        lk_reg, lk_next;
    logic [rgcw_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic                              diag_reg, diag_next;
    logic [1:0]                        step_signs_reg, step_signs_next; // [0] x back, [1] y back

    // ray and walk data
    logic signed [CW-1:0]              x0_reg, x0_next, y0_reg, y0_next;
    logic signed [rgcw_pkg::DIR_W-1:0] ux_reg, ux_next, uy_reg, uy_next;
    logic [rgcw_pkg::LEN_W-1:0]        len_reg, len_next;
    logic signed [DW-1:0]              dx_reg, dx_next, dy_reg, dy_next;
    rgcw_pkg::cell_t                   col_reg, col_next, row_reg, row_next;
    rgcw_pkg::cell_t                   ecol_reg, ecol_next, erow_reg, erow_next;
    logic signed [rgcw_pkg::BND_W-1:0] xd_reg, xd_next, yd_reg, yd_next;
    rgcw_pkg::mul_p_t                  p1_reg, p1_next;
    logic signed [rgcw_pkg::NUM_W-1:0] num_reg, num_next;

    // output register
    logic                              m_valid_reg, m_valid_next;
    rgcw_pkg::cell_t                   m_col_reg, m_col_next, m_row_reg, m_row_next;
    logic                              m_last_reg, m_last_next;

    // shared units
    rgcw_pkg::mul_a_t                  mul_a;
    rgcw_pkg::mul_b_t                  mul_b;
    rgcw_pkg::mul_p_t                  mul_p;
    logic signed [DW-1:0]              mul_delta;
    rgcw_pkg::div_d_t                  div_d;
    logic [rgcw_pkg::LEN_W-1:0]        div_size;
    logic                              div_start, div_done;
    rgcw_pkg::cell_t                   div_q, lk_lim, lk_cell;
    logic signed [CW+1:0]              lk_v;
    logic signed [CW-1:0]              lk_lo;

    // walk decision
    logic                              out_free, at_end, sx_back, sy_back;
    logic signed [rgcw_pkg::NUM_W-1:0] numa;
    logic                              adv_row, adv_col, overshoot;
    logic signed [SW-1:0]              nc7, nr7, ec7, er7, c7, r7;

    assign cw_eff  = (cw_reg == '0) ? rgcw_pkg::LEN_W'(1) : cw_reg;
    assign ch_eff  = (ch_reg == '0) ? rgcw_pkg::LEN_W'(1) : ch_reg;
    assign sx_back = step_signs_reg[0];
    assign sy_back = step_signs_reg[1];
    assign out_free = !m_valid_reg || m_ready;
    assign at_end  = ((col_reg == ecol_reg) && (row_reg == erow_reg)) ||
                     (cnt_reg == rgcw_pkg::CNT_W'(rgcw_pkg::MAX_CELLS));

    // multiplier operand select
    always_comb begin
        case (state_reg)
            ST_EX: begin
                mul_a = rgcw_pkg::MUL_A_W'(len_reg);
                mul_b = rgcw_pkg::MUL_B_W'(ux_reg);
            end
            ST_EY: begin
                mul_a = rgcw_pkg::MUL_A_W'(len_reg);
                mul_b = rgcw_pkg::MUL_B_W'(uy_reg);
            end
            ST_BX: begin
                mul_a = rgcw_pkg::MUL_A_W'({1'b0, col_reg} + 6'(!sx_back));
                mul_b = rgcw_pkg::MUL_B_W'(cw_eff);
            end
            ST_BY: begin
                mul_a = rgcw_pkg::MUL_A_W'({1'b0, row_reg} + 6'(!sy_back));
                mul_b = rgcw_pkg::MUL_B_W'(ch_eff);
            end
            ST_M1: begin
                mul_a = rgcw_pkg::MUL_A_W'(y0_reg) - rgcw_pkg::MUL_A_W'(yd_reg);
                mul_b = rgcw_pkg::MUL_B_W'(dx_reg);
            end
            default: begin
                mul_a = rgcw_pkg::MUL_A_W'(xd_reg) - rgcw_pkg::MUL_A_W'(x0_reg);
                mul_b = rgcw_pkg::MUL_B_W'(dy_reg);
            end
        endcase
    end

    rgcw_mul u_mul (
        .a (mul_a),
        .b (mul_b),
        .p (mul_p)
    );

    // floor(dir * len / 2^14)
    assign mul_delta = signed'(mul_p[rgcw_pkg::FRAC_W+DW-1:rgcw_pkg::FRAC_W]);

    // cell lookup operand select: even lookups are x, odd are y
    always_comb begin
        case (lk_reg)
            LK_COL:  lk_v = (CW+2)'(x0_reg);
            LK_ROW:  lk_v = (CW+2)'(y0_reg);
            LK_ECOL: lk_v = (CW+2)'(x0_reg) + (CW+2)'(dx_reg);
            default: lk_v = (CW+2)'(y0_reg) + (CW+2)'(dy_reg);
        endcase
    end

    assign lk_lo    = lk_reg[0] ? min_y_reg : min_x_reg;
    assign div_size = lk_reg[0] ? ch_eff : cw_eff;
    assign lk_lim   = lk_reg[0] ? ROW_LAST : COL_LAST;
    assign div_d    = rgcw_pkg::DIV_D_W'(lk_v) - rgcw_pkg::DIV_D_W'(lk_lo);
    assign div_start = (state_reg == ST_DIVS);
    assign lk_cell  = (div_q > lk_lim) ? lk_lim : div_q;

    rgcw_cell_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .d       (div_d),
        .size    (div_size),
        .done    (div_done),
        .q       (div_q)
    );

    // Diagonal step: sign of (yl - yd), scaled by dx, decides row vs column.
    assign numa    = dx_reg[DW-1] ? -num_reg : num_reg;
    assign adv_row = sy_back ? (numa <= 0) : (numa >= 0);
    assign adv_col = !adv_row || (numa == 0);
    assign c7  = SW'({1'b0, col_reg});
    assign r7  = SW'({1'b0, row_reg});
    assign ec7 = SW'({1'b0, ecol_reg});
    assign er7 = SW'({1'b0, erow_reg});
    assign nc7 = adv_col ? (sx_back ? c7 - SW'(1) : c7 + SW'(1)) : c7;
    assign nr7 = adv_row ? (sy_back ? r7 - SW'(1) : r7 + SW'(1)) : r7;
    assign overshoot = (sx_back ? (nc7 < ec7) : (nc7 > ec7)) ||
                       (sy_back ? (nr7 < er7) : (nr7 > er7));

    always_comb begin
        state_next      = state_reg;
        lk_next         = lk_reg;
        cnt_next        = cnt_reg;
        diag_next       = diag_reg;
        step_signs_next = step_signs_reg;
        x0_next  = x0_reg;
        y0_next  = y0_reg;
        ux_next  = ux_reg;
        uy_next  = uy_reg;
        len_next = len_reg;
        dx_next  = dx_reg;
        dy_next  = dy_reg;
        col_next = col_reg;
        row_next = row_reg;
        ecol_next = ecol_reg;
        erow_next = erow_reg;
        xd_next  = xd_reg;
        yd_next  = yd_reg;
        p1_next  = p1_reg;
        num_next = num_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_col_next   = m_col_reg;
        m_row_next   = m_row_reg;
        m_last_next  = m_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    x0_next  = s_origin_x;
                    y0_next  = s_origin_y;
                    ux_next  = s_dir_x;
                    uy_next  = s_dir_y;
                    len_next = s_ray_length;
                    lk_next  = LK_COL;
                    state_next = ST_EX;
                end
            end
            ST_EX: begin
                dx_next = mul_delta;
                step_signs_next[0] = (mul_delta <= 0);
                state_next = ST_EY;
            end
            ST_EY: begin
                dy_next = mul_delta;
                step_signs_next[1] = (mul_delta <= 0);
                state_next = ST_DIVS;
            end
            ST_DIVS: begin
                state_next = ST_DIVW;
            end
            ST_DIVW: begin
                if (div_done) begin
                    case (lk_reg)
                        LK_COL:  col_next  = lk_cell;
                        LK_ROW:  row_next  = lk_cell;
                        LK_ECOL: ecol_next = lk_cell;
                        default: erow_next = lk_cell;
                    endcase
                    if (lk_reg == LK_EROW) begin
                        cnt_next = rgcw_pkg::CNT_W'(1);
                        if ((row_reg == lk_cell) || (col_reg == ecol_reg)) begin
                            diag_next  = 1'b0;
                            state_next = ST_CHK;
                        end else begin
                            diag_next  = 1'b1;
                            state_next = ST_BX;
                        end
                    end else begin
                        lk_next    = lk_reg + 2'd1;
                        state_next = ST_DIVS;
                    end
                end
            end
            ST_BX: begin
                xd_next = signed'(mul_p[rgcw_pkg::BND_W-1:0]) +
                          rgcw_pkg::BND_W'(min_x_reg);
                state_next = ST_BY;
            end
            ST_BY: begin
                yd_next = signed'(mul_p[rgcw_pkg::BND_W-1:0]) +
                          rgcw_pkg::BND_W'(min_y_reg);
                state_next = ST_CHK;
            end
            ST_CHK: begin
                if (at_end) begin
                    state_next = ST_FIN;
                end else if (diag_reg) begin
                    state_next = ST_M1;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_col_next   = col_reg;
                    m_row_next   = row_reg;
                    m_last_next  = 1'b0;
                    cnt_next     = cnt_reg + rgcw_pkg::CNT_W'(1);
                    if (row_reg == erow_reg) begin
                        col_next = sx_back ? col_reg - 5'd1 : col_reg + 5'd1;
                    end else begin
                        row_next = sy_back ? row_reg - 5'd1 : row_reg + 5'd1;
                    end
                end
            end
            ST_M1: begin
                p1_next    = mul_p;
                state_next = ST_M2;
            end
            ST_M2: begin
                num_next   = rgcw_pkg::NUM_W'(p1_reg) + rgcw_pkg::NUM_W'(mul_p);
                state_next = ST_DEC;
            end
            ST_DEC: begin
                if (overshoot) begin
                    state_next = ST_FIN;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_col_next   = col_reg;
                    m_row_next   = row_reg;
                    m_last_next  = 1'b0;
                    cnt_next     = cnt_reg + rgcw_pkg::CNT_W'(1);
                    col_next     = nc7[rgcw_pkg::CELL_W-1:0];
                    row_next     = nr7[rgcw_pkg::CELL_W-1:0];
                    if (adv_col) begin
                        xd_next = sx_back ? xd_reg - rgcw_pkg::BND_W'(cw_eff)
                                          : xd_reg + rgcw_pkg::BND_W'(cw_eff);
                    end
                    if (adv_row) begin
                        yd_next = sy_back ? yd_reg - rgcw_pkg::BND_W'(ch_eff)
                                          : yd_reg + rgcw_pkg::BND_W'(ch_eff);
                    end
                    state_next = ST_CHK;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_col_next   = col_reg;
                    m_row_next   = row_reg;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            lk_reg         <= LK_COL;
            cnt_reg        <= '0;
            diag_reg       <= 1'b0;
            step_signs_reg <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            ecol_reg       <= '0;
            erow_reg       <= '0;
            m_valid_reg    <= 1'b0;
            min_x_reg      <= rgcw_pkg::MIN_X_RST;
            min_y_reg      <= rgcw_pkg::MIN_Y_RST;
            cw_reg         <= rgcw_pkg::CELL_W_RST;
            ch_reg         <= rgcw_pkg::CELL_H_RST;
        end else begin
            state_reg      <= state_next;
            lk_reg         <= lk_next;
            cnt_reg        <= cnt_next;
            diag_reg       <= diag_next;
            step_signs_reg <= step_signs_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            ecol_reg       <= ecol_next;
            erow_reg       <= erow_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    rgcw_pkg::CFG_MIN_X:       min_x_reg <= signed'(cfg_data);
                    rgcw_pkg::CFG_MIN_Y:       min_y_reg <= signed'(cfg_data);
                    rgcw_pkg::CFG_CELL_WIDTH:  cw_reg <= cfg_data[rgcw_pkg::LEN_W-1:0];
                    rgcw_pkg::CFG_CELL_HEIGHT: ch_reg <= cfg_data[rgcw_pkg::LEN_W-1:0];
                    default: ;
                endcase
            end
        end
        x0_reg    <= x0_next;
        y0_reg    <= y0_next;
        ux_reg    <= ux_next;
        uy_reg    <= uy_next;
        len_reg   <= len_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        xd_reg    <= xd_next;
        yd_reg    <= yd_next;
        p1_reg    <= p1_next;
        num_reg   <= num_next;
        m_col_reg <= m_col_next;
        m_row_reg <= m_row_next;
        m_last_reg <= m_last_next;
    end

    assign cfg_ready   = 1'b1;
    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_cell_col  = m_col_reg;
    assign m_cell_row  = m_row_reg;
    assign m_last_cell = m_last_reg;

    // emitted cells stay inside the grid
    a_cell_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_cell_col <= COL_LAST) && (m_cell_row <= ROW_LAST))
        else $error("cell word outside the grid");

    // never more than the cell cap per ray
    a_cnt_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= rgcw_pkg::CNT_W'(rgcw_pkg::MAX_CELLS))
        else $error("cell count past cap");

    // a taken ray closes the input until its walk ends
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready right after accept");

    // closing a walk always presents a word marked last
    a_fin_marks_last: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_FIN) && out_free) |=> (m_valid && m_last_cell))
        else $error("walk closed without last word");

endmodule

[src/rgcw_mul.sv]
// Shared signed multiplier, combinational; the sequencer registers its result.
module rgcw_mul (
    input  rgcw_pkg::mul_a_t a,
    input  rgcw_pkg::mul_b_t b,
    output rgcw_pkg::mul_p_t p
);

    assign p = a * b;

endmodule

[src/rgcw_cell_div.sv]
// Restoring divider, one quotient bit per cycle, quotient saturates at 31.
// Negative dividend gives 0.
module rgcw_cell_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  rgcw_pkg::div_d_t            d,
    input  logic [rgcw_pkg::LEN_W-1:0]  size,
    output logic                        done,
    output rgcw_pkg::cell_t             q
);

    logic [rgcw_pkg::DIV_D_W-1:0] rem_reg, rem_next;
    rgcw_pkg::cell_t              q_reg, q_next;
    logic [2:0]                   k_reg, k_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [rgcw_pkg::DIV_D_W-1:0] trial;
    logic                         fits;

    assign trial = rgcw_pkg::DIV_D_W'(size) << k_reg;
    assign fits  = rem_reg >= trial;

    always_comb begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        k_next    = k_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = d[rgcw_pkg::DIV_D_W-1] ? '0 : d;
            q_next    = '0;
            k_next    = 3'(rgcw_pkg::QBITS - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = rem_reg - trial;
                q_next[k_reg] = 1'b1;
            end
            if (k_reg == 3'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                k_next = k_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            k_reg    <= k_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

[tb/ray_grid_cell_walk_tb.sv]
module ray_grid_cell_walk_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rgcw_pkg::*;

    // Grid size the block is built with
    localparam int N_COLS = 10;
    localparam int N_ROWS = 15;

    // Register indexes outside the map; writes to them must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 8'd255;

    // Cycles to let pass once the last cell word is back: covers the close
    // of a walk plus a long diagonal walk, so nothing is still in flight.
    localparam int SETTLE_CYCLES = 140;

    typedef struct {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [DIR_W-1:0]   dir_x;
        logic signed [DIR_W-1:0]   dir_y;
        logic [LEN_W-1:0]          length;
    } ray_t;

    typedef struct {
        cell_t col;
        cell_t row;
        logic  last;
    } cell_word_t;

    // ------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------
    logic aclk;
    logic aresetn = 1'b0;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [COORD_W-1:0]    cfg_data  = '0;

    logic                       s_valid      = 1'b0;
    logic                       s_ready;
    logic signed [COORD_W-1:0]  s_origin_x   = '0;
    logic signed [COORD_W-1:0]  s_origin_y   = '0;
    logic signed [DIR_W-1:0]    s_dir_x      = '0;
    logic signed [DIR_W-1:0]    s_dir_y      = '0;
    logic [LEN_W-1:0]           s_ray_length = '0;

    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [CELL_W-1:0]     m_cell_col;
    logic [CELL_W-1:0]     m_cell_row;
    logic                  m_last_cell;

    ray_grid_cell_walk #(
        .GRID_COLUMNS (N_COLS),
        .GRID_ROWS    (N_ROWS)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_origin_x   (s_origin_x),
        .s_origin_y   (s_origin_y),
        .s_dir_x      (s_dir_x),
        .s_dir_y      (s_dir_y),
        .s_ray_length (s_ray_length),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cell_col   (m_cell_col),
        .m_cell_row   (m_cell_row),
        .m_last_cell  (m_last_cell)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Shadow of the grid registers and the queue of cells still owed
    // ------------------------------------------------------------------
    longint grid_min_x = longint'(MIN_X_RST);
    longint grid_min_y = longint'(MIN_Y_RST);
    longint grid_cell_w = longint'(CELL_W_RST);
    longint grid_cell_h = longint'(CELL_H_RST);

    cell_word_t cells_expected[$];
    int         mismatches = 0;
    bit         idle_en = 1'b1;    // random gaps / stalls on both channels

    // Floor division for a positive divisor
    function automatic longint floor_quot(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) q -= 1;
        return q;
    endfunction

    // Cell index of a coordinate, clamped into the grid
    function automatic int clamp_cell(longint v, longint lo, longint size, int count);
        longint q;
        q = floor_quot(v - lo, size);
        if (q < 0) q = 0;
        if (q > count - 1) q = count - 1;
        return int'(q);
    endfunction

    function automatic void add_cell(int col, int row);
        cell_word_t w;
        w.col  = cell_t'(col);
        w.row  = cell_t'(row);
        w.last = 1'b0;
        cells_expected.push_back(w);
    endfunction

    // Walks the ray over the shadow grid and queues each cell it crosses, up to the cell cap.
    // The step decision is done exactly: the sign of (yl - yd) * dx, with
    // dx folded positive, tells which boundary the line reaches first.
    function automatic void predict_walk(ray_t ray);
        longint x0, y0, x1, y1, cw, ch, dx, dy, xd, yd, num;
        int sx, sy, col, row, end_c, end_r, nc, nr, n;
        x0 = longint'(ray.origin_x);
        y0 = longint'(ray.origin_y);
        cw = (grid_cell_w < 1) ? 1 : grid_cell_w;   // zero size acts as one
        ch = (grid_cell_h < 1) ? 1 : grid_cell_h;
        x1 = x0 + floor_quot(longint'(ray.dir_x) * longint'(ray.length), 16384);
        y1 = y0 + floor_quot(longint'(ray.dir_y) * longint'(ray.length), 16384);
        // equal coordinates count as stepping backward
        sx = (x0 >= x1) ? -1 : 1;
        sy = (y0 >= y1) ? -1 : 1;
        col   = clamp_cell(x0, grid_min_x, cw, N_COLS);
        row   = clamp_cell(y0, grid_min_y, ch, N_ROWS);
        end_c = clamp_cell(x1, grid_min_x, cw, N_COLS);
        end_r = clamp_cell(y1, grid_min_y, ch, N_ROWS);
        add_cell(col, row);
        n = 1;
        if (row == end_r) begin
            while (col != end_c && n < MAX_CELLS) begin
                col += sx;
                add_cell(col, row);
                n++;
            end
        end else if (col == end_c) begin
            while (row != end_r && n < MAX_CELLS) begin
                row += sy;
                add_cell(col, row);
                n++;
            end
        end else begin
            dx = x1 - x0;
            dy = y1 - y0;
            while ((col != end_c || row != end_r) && n < MAX_CELLS) begin
                yd = (longint'(row) + ((sy > 0) ? 1 : 0)) * ch + grid_min_y;
                xd = (longint'(col) + ((sx > 0) ? 1 : 0)) * cw + grid_min_x;
                num = (y0 - yd) * dx + (xd - x0) * dy;
                if (dx < 0) num = -num;
                nc = col;
                nr = row;
                if ((sy > 0) ? (num >= 0) : (num <= 0)) begin
                    nr = row + sy;
                    if (num == 0) nc = col + sx;    // exact corner: both axes
                end else begin
                    nc = col + sx;
                end
                // overshoot past the end cell stops the walk (also off-grid)
                if ((sx > 0) ? (nc > end_c) : (nc < end_c)) break;
                if ((sy > 0) ? (nr > end_r) : (nr < end_r)) break;
                col = nc;
                row = nr;
                add_cell(col, row);
                n++;
            end
        end
        cells_expected[cells_expected.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall bursts, compare every word
    // ------------------------------------------------------------------
    initial begin : sink_pacing
        int hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                hold = $urandom_range(0, 4);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic void report_mismatch(string field, int want, int got);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
    endfunction

    always @(posedge aclk) begin : check_cells
        cell_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (cells_expected.size() == 0) begin
                mismatches++;
                $display("%0t: cell word with nothing expected, got col %0d row %0d last %0b",
                         $realtime, m_cell_col, m_cell_row, m_last_cell);
            end else begin
                want = cells_expected.pop_front();
                if (m_cell_col !== want.col)
                    report_mismatch("cell_col", want.col, m_cell_col);
                if (m_cell_row !== want.row)
                    report_mismatch("cell_row", want.row, m_cell_row);
                if (m_last_cell !== want.last)
                    report_mismatch("last_cell", want.last, m_last_cell);
            end
        end
    end

    // ------------------------------------------------------------------
    // Driving tasks. All are entered right at a rising edge.
    // ------------------------------------------------------------------

    // One config write; cfg_valid drops after each word.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_MIN_X:       grid_min_x  = longint'($signed(data));
            CFG_MIN_Y:       grid_min_y  = longint'($signed(data));
            CFG_CELL_WIDTH:  grid_cell_w = longint'(data[LEN_W-1:0]);
            CFG_CELL_HEIGHT: grid_cell_h = longint'(data[LEN_W-1:0]);
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Whole grid setup; bit 15 of the size words is junk the block masks off
    task automatic set_grid(int mx, int my, int cw, int ch);
        write_reg(CFG_MIN_X, 16'(mx));
        write_reg(CFG_MIN_Y, 16'(my));
        write_reg(CFG_CELL_WIDTH, {1'($urandom_range(0, 1)), 15'(cw)});
        write_reg(CFG_CELL_HEIGHT, {1'($urandom_range(0, 1)), 15'(ch)});
    endtask

    // Presents one ray and returns at the edge that takes it. s_valid is
    // left high so a following ray goes out back to back; any caller that
    // stops sending calls drain_walks in the same step.
    task automatic send_ray(ray_t ray);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        predict_walk(ray);
        s_valid      <= 1'b1;
        s_origin_x   <= ray.origin_x;
        s_origin_y   <= ray.origin_y;
        s_dir_x      <= ray.dir_x;
        s_dir_y      <= ray.dir_y;
        s_ray_length <= ray.length;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stop sending, wait for every owed cell, then let the block go idle
    task automatic drain_walks();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (cells_expected.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic ray_t ray_of(int ox, int oy, int dx, int dy, int len);
        ray_t ray;
        ray.origin_x = 16'(ox);
        ray.origin_y = 16'(oy);
        ray.dir_x    = 16'(dx);
        ray.dir_y    = 16'(dy);
        ray.length   = 15'(len);
        return ray;
    endfunction

    function automatic int clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    // Mostly rays that start on the grid, with a length up to its larger span,
    // some aimed through cell corners on square grids, a fifth pure noise.
    function automatic ray_t random_ray();
        ray_t   ray;
        longint cw, ch, span_x, span_y, reach, off;
        cw = (grid_cell_w < 1) ? 1 : grid_cell_w;
        ch = (grid_cell_h < 1) ? 1 : grid_cell_h;
        span_x = cw * N_COLS;
        span_y = ch * N_ROWS;
        ray.dir_x = 16'(int'($urandom_range(0, 32768)) - 16384);
        ray.dir_y = 16'(int'($urandom_range(0, 32768)) - 16384);
        if ($urandom_range(0, 4) == 0) begin
            ray.origin_x = 16'($urandom);
            ray.origin_y = 16'($urandom);
            ray.length   = 15'($urandom);
        end else begin
            off = $urandom_range(0, int'(span_x - 1));
            ray.origin_x = 16'(clip16(grid_min_x + off));
            ray.origin_y = 16'(clip16(grid_min_y + $urandom_range(0, int'(span_y - 1))));
            if (cw == ch && $urandom_range(0, 2) == 0) begin
                // same offset inside its cell on both axes, 45 degree heading
                ray.origin_y = 16'(clip16(grid_min_y
                               + $urandom_range(0, N_ROWS - 1) * ch + off % cw));
                ray.dir_y = ray.dir_x;
            end
            reach = (span_x > span_y) ? span_x : span_y;
            if (reach > 32767) reach = 32767;
            ray.length = 15'($urandom_range(0, int'(reach)));
        end
        return ray;
    endfunction

    task automatic pick_random_grid(bit wild);
        int cw, ch, mx, my;
        if (wild) begin
            cw = $urandom_range(0, 32767);
            ch = $urandom_range(0, 32767);
            mx = int'($urandom_range(0, 65535)) - 32768;
            my = int'($urandom_range(0, 65535)) - 32768;
        end else begin
            cw = $urandom_range(40, 3000);
            ch = ($urandom_range(0, 2) == 0) ? cw : $urandom_range(40, 2000);
            // keep the whole grid inside the coordinate range
            mx = int'($urandom_range(0, 65535 - cw * N_COLS)) - 32768;
            my = int'($urandom_range(0, 65535 - ch * N_ROWS)) - 32768;
        end
        set_grid(mx, my, cw, ch);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset grid: degenerate rays, straight walks both ways, long
    // diagonals, field extremes, off-grid starts.
    task automatic test_default_grid();
        send_ray(ray_of(0, 0, 16384, 0, 0));                 // zero length
        send_ray(ray_of(0, 0, 0, 0, 1000));                  // zero direction
        send_ray(ray_of(-2000, 100, 16384, 0, 4000));        // along row, +x
        send_ray(ray_of(2000, 100, -16384, 0, 4000));        // along row, -x
        send_ray(ray_of(0, -3500, 0, 16384, 7000));          // along column, +y
        send_ray(ray_of(0, 3800, 0, -16384, 7000));          // along column, -y
        send_ray(ray_of(-2040, -3580, 6000, 15240, 32767));
        send_ray(ray_of(2000, 3800, -11585, -11585, 32767));
        send_ray(ray_of(-32768, -32768, 16384, 16384, 32767));
        send_ray(ray_of(32767, 32767, -16384, -16384, 32767));
        send_ray(ray_of(-32768, 0, -16384, 1000, 5000));     // heads off the grid
        send_ray(ray_of(-1500, 3000, 16384, -16384, 3000));
        drain_walks();
    endtask

    // Every register at its extremes, zero cell size, and unmapped indexes
    task automatic test_register_extremes();
        write_reg(CFG_UNUSED_LO, 16'hFFFF);
        write_reg(CFG_UNUSED_HI, 16'h1234);
        send_ray(ray_of(-1000, -2000, 9000, 13000, 6000));   // still the reset grid
        drain_walks();
        set_grid(-32768, -32768, 32767, 32767);
        send_ray(ray_of(-32768, -32768, 16384, 16384, 32767));
        send_ray(ray_of(32767, 32767, -16384, -9000, 32767));
        drain_walks();
        set_grid(32767, 32767, 1, 1);                        // everything clamps to 0
        send_ray(ray_of(100, -100, 16384, -16384, 500));
        drain_walks();
        set_grid(0, 0, 0, 0);                                // zero size acts as one
        send_ray(ray_of(0, 0, 11585, 9000, 20));
        send_ray(ray_of(9, 14, -16384, -3000, 12));
        drain_walks();
        set_grid(-100, 200, 1, 32767);
        send_ray(ray_of(-95, 300, 16384, 100, 30));
        drain_walks();
    endtask

    // Square cells, lines through exact cell corners: ties move both axes
    task automatic test_corner_ties();
        set_grid(0, 0, 256, 256);
        send_ray(ray_of(128, 128, 11585, 11585, 1280));
        send_ray(ray_of(1200, 1200, -11585, -11585, 1000));
        send_ray(ray_of(64, 64, 16384, 16384, 2000));
        send_ray(ray_of(2496, 64, -16384, 16384, 2000));
        drain_walks();
    endtask

    // Random grids and rays; one phase without idling, one with a wild grid
    task automatic test_random_walks();
        for (int phase = 0; phase < 6; phase++) begin
            idle_en = (phase != 3);
            pick_random_grid(phase == 5);
            repeat (50) send_ray(random_ray());
            drain_walks();
        end
        idle_en = 1'b1;
    endtask

    // Sender holds off until every owed cell is back, then resumes
    task automatic test_pause_for_drain();
        pick_random_grid(1'b0);
        repeat (3) begin
            repeat (10) send_ray(random_ray());
            drain_walks();
        end
    endtask

    // Closing stretch: no gaps and no stalls, rays back to back
    task automatic test_back_to_back();
        idle_en = 1'b0;
        pick_random_grid(1'b0);
        repeat (30) send_ray(random_ray());
        drain_walks();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_grid();
        test_register_extremes();
        test_corner_ties();
        test_random_walks();
        test_pause_for_drain();
        test_back_to_back();
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
